// File: design/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: design/htd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

   localparam int SYM_W  = 8;
   localparam int CODE_W = 32;
   localparam int LEN_W  = 6;
   localparam int KIND_W = 3;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DECODE = 2'd2,
      REQ_UNUSED = 2'd3
   } htd_req_type;

   // Result codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_SYMBOL   = 3'd0,
      KIND_INSERTED = 3'd1,
      KIND_FULL     = 3'd2,
      KIND_NO_PATH  = 3'd3,
      KIND_CLEARED  = 3'd4
   } htd_kind_type;

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_WALK   = 7'b0000010,
      ST_LOAD   = 7'b0000100,
      ST_DREAD  = 7'b0001000,
      ST_DCHILD = 7'b0010000,
      ST_DLEAF  = 7'b0100000,
      ST_RESULT = 7'b1000000
   } htd_state_type;

   // Result handed from the sequencer to the output register.
   typedef struct packed {
      htd_kind_type     kind;
      logic [SYM_W-1:0] sym;
   } htd_result_type;

endpackage

`default_nettype wire

// File: design/htd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module htd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/htd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module htd_core import htd_pkg::*; #(
   parameter int NODE_COUNT   = 512,
   parameter int MAX_CODE_LEN = 32,
   localparam int IW = $clog2(NODE_COUNT),
   localparam int NW = 2 * IW + 1 + SYM_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_type,
   input  wire logic [SYM_W-1:0]  req_symbol,
   input  wire logic [CODE_W-1:0] req_code_bits,
   input  wire logic [LEN_W-1:0]  req_code_length,
   input  wire logic              req_stream_bit,
   output logic                   res_valid,
   input  wire logic              res_take,
   output htd_result_type         res,
   output logic                   ram_we,
   output logic      [IW-1:0]     ram_waddr,
   output logic      [NW-1:0]     ram_wdata,
   output logic      [IW-1:0]     ram_raddr,
   input  wire logic [NW-1:0]     ram_rdata
);

   localparam int FW = $clog2(NODE_COUNT + 1);
   localparam int RW = $clog2(MAX_CODE_LEN + 1);
   localparam int PW = (RW > LEN_W) ? RW : LEN_W;

   htd_state_type     state_ff, state_in;
   logic [NW-1:0]     root_ff, root_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [FW-1:0]     free_ff, free_in;
   logic [IW-1:0]     cursor_ff, cursor_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              dir_ff, dir_in;
   htd_result_type    res_ff, res_in;

   logic              accept;
   logic [IW-1:0]     cur_left, cur_right, cur_next;
   logic [PW-1:0]     pos_wide, len_wide;
   logic              walk_dir;
   logic [NW-1:0]     wb_node;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign res_valid = (state_ff == ST_RESULT);
   assign res       = res_ff;

   // Fields of the node held in the work register.
   assign cur_left  = cur_ff[NW-1 -: IW];
   assign cur_right = cur_ff[NW-1-IW -: IW];

   // Code bit for the current walk step; positions past the code word read as zero.
   assign pos_wide = PW'(rem_ff) - PW'(1);
   assign walk_dir = (pos_wide < PW'(CODE_W)) ? code_ff[pos_wide[4:0]] : 1'b0;
   assign cur_next = (state_ff == ST_WALK ? walk_dir : dir_ff) ? cur_right : cur_left;
   assign len_wide = PW'(req_code_length);

   // Sequencer: at most one store read and one store write per step.
   always_comb begin
      state_in  = state_ff;
      root_in   = root_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      free_in   = free_ff;
      cursor_in = cursor_ff;
      rem_in    = rem_ff;
      code_in   = code_ff;
      sym_in    = sym_ff;
      dir_in    = dir_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_raddr = '0;
      wb_node   = cur_ff;
      ram_wdata = wb_node;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_CLEAR: begin
                     root_in    = '0;
                     free_in    = FW'(1);
                     cursor_in  = '0;
                     res_in     = '{kind: KIND_CLEARED, sym: '0};
                     state_in   = ST_RESULT;
                  end
                  REQ_INSERT: begin
                     cur_in   = root_ff;
                     idx_in   = '0;
                     code_in  = req_code_bits;
                     sym_in   = req_symbol;
                     rem_in   = (len_wide > PW'(MAX_CODE_LEN)) ? RW'(MAX_CODE_LEN)
                                                              : RW'(len_wide);
                     state_in = ST_WALK;
                  end
                  REQ_DECODE: begin
                     dir_in = req_stream_bit;
                     if (cursor_ff == '0) begin
                        cur_in   = root_ff;
                        state_in = ST_DCHILD;
                     end else begin
                        ram_raddr = cursor_ff;
                        state_in  = ST_DREAD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Insert walk: the node in the work register is always written back.
         ST_WALK: begin
            if (rem_ff == '0) begin
               wb_node[SYM_W]     = 1'b1;
               wb_node[SYM_W-1:0] = sym_ff;
               res_in   = '{kind: KIND_INSERTED, sym: '0};
               state_in = ST_RESULT;
            end else if (cur_next != '0) begin
               ram_raddr = cur_next;
               idx_in    = cur_next;
               state_in  = ST_LOAD;
            end else if (free_ff >= FW'(NODE_COUNT)) begin
               res_in   = '{kind: KIND_FULL, sym: '0};
               state_in = ST_RESULT;
            end else begin
               if (walk_dir) begin
                  wb_node[NW-1-IW -: IW] = free_ff[IW-1:0];
               end else begin
                  wb_node[NW-1 -: IW] = free_ff[IW-1:0];
               end
               cur_in  = '0;
               idx_in  = free_ff[IW-1:0];
               free_in = free_ff + FW'(1);
               rem_in  = rem_ff - RW'(1);
            end
            ram_wdata = wb_node;
            if (idx_ff == '0) begin
               root_in = wb_node;
            end else begin
               ram_we = 1'b1;
            end
         end

         ST_LOAD: begin
            cur_in   = ram_rdata;
            rem_in   = rem_ff - RW'(1);
            state_in = ST_WALK;
         end

         ST_DREAD: begin
            cur_in   = ram_rdata;
            state_in = ST_DCHILD;
         end

         // Step to the selected child, or report a missing one.
         ST_DCHILD: begin
            if (cur_next == '0) begin
               cursor_in = '0;
               res_in    = '{kind: KIND_NO_PATH, sym: '0};
               state_in  = ST_RESULT;
            end else begin
               ram_raddr = cur_next;
               idx_in    = cur_next;
               state_in  = ST_DLEAF;
            end
         end

         ST_DLEAF: begin
            if (ram_rdata[SYM_W]) begin
               cursor_in = '0;
               res_in    = '{kind: KIND_SYMBOL, sym: ram_rdata[SYM_W-1:0]};
               state_in  = ST_RESULT;
            end else begin
               cursor_in = idx_ff;
               state_in  = ST_IDLE;
            end
         end

         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, the root node, the next free node and the cursor.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         root_ff   <= '0;
         free_ff   <= FW'(1);
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         root_ff   <= root_in;
         free_ff   <= free_in;
         cursor_ff <= cursor_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      code_ff <= code_in;
      sym_ff  <= sym_in;
      dir_ff  <= dir_in;
      res_ff  <= res_in;
   end

endmodule

`default_nettype wire

// File: design/huffman_tree_decoder.sv
// A clear goes from idle straight to the result state; a bit request reads the cursor
// node unless it is the root, then the selected child; an insert loads each existing
// node it passes and allocates the missing ones. The sequencer holds one request at a
// time: an unused request type leaves it idle, a clear frees the input once its result
// is taken, others after their walk. Reset empties the root, sets the next free node to
// 1 and the cursor to the root; other nodes are written on allocation, no sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module huffman_tree_decoder import htd_pkg::*; #(
   parameter int NODE_COUNT   = 512,
   parameter int MAX_CODE_LEN = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_type,
   input  wire logic [SYM_W-1:0]  req_symbol,
   input  wire logic [CODE_W-1:0] req_code_bits,
   input  wire logic [LEN_W-1:0]  req_code_length,
   input  wire logic              req_stream_bit,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [KIND_W-1:0] rsp_kind,
   output logic      [SYM_W-1:0]  rsp_decoded_symbol
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int NW = 2 * IW + 1 + SYM_W;

   logic             res_valid, res_take;
   htd_result_type   res;
   logic             ram_we;
   logic [IW-1:0]    ram_waddr, ram_raddr;
   logic [NW-1:0]    ram_wdata, ram_rdata;

   logic             rsp_valid_ff, rsp_valid_in;
   htd_kind_type     rsp_kind_ff, rsp_kind_in;
   logic [SYM_W-1:0] rsp_sym_ff, rsp_sym_in;

   htd_core #(
      .NODE_COUNT  (NODE_COUNT),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_symbol     (req_symbol),
      .req_code_bits  (req_code_bits),
      .req_code_length(req_code_length),
      .req_stream_bit (req_stream_bit),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res            (res),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata)
   );

   htd_ram #(
      .WIDTH(NW),
      .DEPTH(NODE_COUNT)
   ) u_node_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Output register: loads a new result once the previous one has been taken.
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sym_in   = rsp_sym_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = res.kind;
         rsp_sym_in   = res.sym;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_sym_ff  <= rsp_sym_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_decoded_symbol = rsp_sym_ff;

   // A clear request always yields a result on the next cycle.
   `ASSERT_NEXT(a_clear_gives_result, clock, reset, req_valid && !req_stall && req_type == REQ_CLEAR, res_valid && res.kind == KIND_CLEARED)
   // An unused request code leaves the block ready.
   `ASSERT_NEXT(a_unused_stays_ready, clock, reset, req_valid && !req_stall && req_type == REQ_UNUSED, !req_stall)
   // Only decoded symbols carry a nonzero symbol.
   `ASSERT_SAME(a_symbol_only_on_decode, clock, reset, rsp_valid && rsp_kind != KIND_SYMBOL, rsp_decoded_symbol == '0)

endmodule

`default_nettype wire

// File: tb/huffman_tree_decoder_tb.sv
`timescale 1ns / 1ps

module huffman_tree_decoder_tb import htd_pkg::*;;

   localparam int NODE_COUNT   = 512;
   localparam int MAX_CODE_LEN = 32;
   localparam int IDX_W        = 9;
   localparam int TARGET_REQS  = 1400;

   // One pending request as the driver will present it.
   typedef struct {
      htd_req_type       rtype;
      logic [SYM_W-1:0]  sym;
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
      logic              sbit;
      int                phase;
      bit                hold;
   } tree_request_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_type;
   logic [SYM_W-1:0]  req_symbol;
   logic [CODE_W-1:0] req_code_bits;
   logic [LEN_W-1:0]  req_code_length;
   logic              req_stream_bit;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [KIND_W-1:0] rsp_kind;
   logic [SYM_W-1:0]  rsp_decoded_symbol;

   // Private copy of the code tree.
   logic [IDX_W-1:0]  left_child  [NODE_COUNT];
   logic [IDX_W-1:0]  right_child [NODE_COUNT];
   logic              is_leaf     [NODE_COUNT];
   logic [SYM_W-1:0]  leaf_sym    [NODE_COUNT];
   logic [IDX_W:0]    next_free;
   logic [IDX_W-1:0]  cursor;

   tree_request_type  pending_requests[$];
   htd_result_type    awaited_outcomes[$];
   int                queued_total;
   int                counted_reqs;
   int                accepted_total;
   int                mismatch_count;
   int                drive_phase;
   logic              req_taken;

   huffman_tree_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_symbol         (req_symbol),
      .req_code_bits      (req_code_bits),
      .req_code_length    (req_code_length),
      .req_stream_bit     (req_stream_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_decoded_symbol (rsp_decoded_symbol)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Idle rates for the four traffic phases: none, sender, receiver, both.
   function automatic int sender_idle_pct(input int phase);
      return (phase == 1) ? 55 : (phase == 3) ? 33 : 0;
   endfunction

   function automatic int rsp_stall_pct(input int phase);
      return (phase == 2) ? 55 : (phase == 3) ? 33 : 0;
   endfunction

   function automatic void empty_tree();
      left_child[0]  = '0;
      right_child[0] = '0;
      is_leaf[0]     = 1'b0;
      leaf_sym[0]    = '0;
      next_free      = (IDX_W + 1)'(1);
      cursor         = '0;
   endfunction

   // Apply one accepted request to the tree copy and queue its outcome, if any.
   function automatic void tree_step(input htd_req_type rtype, input logic [SYM_W-1:0] sym,
         input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len, input logic sbit);
      htd_result_type   res;
      int               walk_len;
      int               pos;
      logic [IDX_W-1:0] node;
      logic [IDX_W-1:0] nxt;
      logic             dir;
      res.kind = KIND_CLEARED;
      res.sym  = '0;
      case (rtype)
         REQ_CLEAR: begin
            empty_tree();
            awaited_outcomes = {awaited_outcomes, res};
         end
         REQ_INSERT: begin
            walk_len = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
            node     = '0;
            res.kind = KIND_INSERTED;
            // Walk from the root, most significant code bit first.
            for (pos = walk_len - 1; pos >= 0; pos--) begin
               dir = bits[pos];
               nxt = dir ? right_child[node] : left_child[node];
               if (nxt == '0) begin
                  if (next_free >= NODE_COUNT) begin
                     res.kind = KIND_FULL;
                     break;
                  end
                  nxt = next_free[IDX_W-1:0];
                  next_free++;
                  left_child[nxt]  = '0;
                  right_child[nxt] = '0;
                  is_leaf[nxt]     = 1'b0;
                  leaf_sym[nxt]    = '0;
                  if (dir) right_child[node] = nxt;
                  else left_child[node] = nxt;
               end
               node = nxt;
            end
            if (res.kind == KIND_INSERTED) begin
               is_leaf[node]  = 1'b1;
               leaf_sym[node] = sym;
            end
            awaited_outcomes = {awaited_outcomes, res};
         end
         REQ_DECODE: begin
            nxt = sbit ? right_child[cursor] : left_child[cursor];
            if (nxt == '0) begin
               cursor   = '0;
               res.kind = KIND_NO_PATH;
               awaited_outcomes = {awaited_outcomes, res};
            end else if (is_leaf[nxt]) begin
               cursor   = '0;
               res.kind = KIND_SYMBOL;
               res.sym  = leaf_sym[nxt];
               awaited_outcomes = {awaited_outcomes, res};
            end else begin
               cursor = nxt;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic push_request(input htd_req_type t, input int unsigned s,
         input int unsigned b, input int unsigned l, input int unsigned sb,
         input bit hold);
      tree_request_type r;
      r.rtype = t;
      r.sym   = s[SYM_W-1:0];
      r.bits  = b[CODE_W-1:0];
      r.len   = l[LEN_W-1:0];
      r.sbit  = sb[0];
      r.phase = (counted_reqs / 60) % 4;
      r.hold  = hold;
      pending_requests = {pending_requests, r};
      queued_total++;
      if (t != REQ_UNUSED) counted_reqs++;
   endtask

   // Driver: presents the next request at the falling edge and drives the result stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_requests.size() != 0 &&
                !(pending_requests[0].hold && awaited_outcomes.size() != 0) &&
                $urandom_range(0, 99) >= sender_idle_pct(pending_requests[0].phase)) begin
               req_type        <= pending_requests[0].rtype;
               req_symbol      <= pending_requests[0].sym;
               req_code_bits   <= pending_requests[0].bits;
               req_code_length <= pending_requests[0].len;
               req_stream_bit  <= pending_requests[0].sbit;
               req_valid       <= 1'b1;
               drive_phase = pending_requests[0].phase;
               void'(pending_requests.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct(drive_phase));
      end
   end

   // Monitor: updates the tree copy on each accepted request and checks each result.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= (req_valid && req_stall === 1'b0);
         if (req_valid && req_stall === 1'b0) begin
            accepted_total++;
            tree_step(htd_req_type'(req_type), req_symbol, req_code_bits, req_code_length,
                      req_stream_bit);
         end
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (awaited_outcomes.size() == 0) begin
               flag_mismatch($sformatf("result kind %0d with no request outstanding",
                                       rsp_kind));
            end else begin
               if (rsp_kind !== awaited_outcomes[0].kind)
                  flag_mismatch($sformatf("kind %0d, expected %0d", rsp_kind,
                                          awaited_outcomes[0].kind));
               if (rsp_decoded_symbol !== awaited_outcomes[0].sym)
                  flag_mismatch($sformatf("symbol %02h, expected %02h", rsp_decoded_symbol,
                                          awaited_outcomes[0].sym));
               void'(awaited_outcomes.pop_front());
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [CODE_W-1:0] set_bits[$];
      int                set_len[$];
      logic [CODE_W-1:0] junk;
      logic [CODE_W-1:0] fill_bits;
      int                fill_len;
      int                leaves;
      int                depth_cap;
      int                pick;
      int                pos;
      int                episode;
      int                t;
      int                len;
      bit                hold;

      reset           = 1'b1;
      req_valid       = 1'b0;
      rsp_stall       = 1'b0;
      req_type        = REQ_CLEAR;
      req_symbol      = '0;
      req_code_bits   = '0;
      req_code_length = '0;
      req_stream_bit  = 1'b0;
      queued_total    = 0;
      counted_reqs    = 0;
      accepted_total  = 0;
      mismatch_count  = 0;
      drive_phase     = 0;
      empty_tree();

      // Directed part: empty tree, empty code, long codes, overwrite, prefix, ignored type.
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd0, 1'b0);
      push_request(REQ_INSERT, 32'hFF, 32'h0, 32'd0, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'hFF, 32'hFFFF_FFFF, 32'h3F, 32'd1, 1'b0);
      push_request(REQ_INSERT, 32'h00, 32'h0, 32'd1, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd0, 1'b0);
      push_request(REQ_INSERT, 32'h5A, 32'hAAAA_AAAA, 32'd63, 32'd0, 1'b0);
      push_request(REQ_INSERT, 32'hA5, 32'h8000_0001, 32'd33, 32'd1, 1'b0);
      push_request(REQ_INSERT, 32'hFF, 32'hFFFF_FFFF, 32'd32, 32'd1, 1'b0);
      push_request(REQ_INSERT, 32'h3C, 32'hFFFF_FFFE, 32'd1, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd0, 1'b1);
      push_request(REQ_INSERT, 32'h77, 32'h1, 32'd1, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd1, 1'b0);
      push_request(REQ_UNUSED, 32'hFF, 32'hFFFF_FFFF, 32'h3F, 32'd1, 1'b0);
      push_request(REQ_CLEAR, 32'h00, 32'h0, 32'd0, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd1, 1'b0);
      push_request(REQ_INSERT, 32'h01, 32'h2, 32'd2, 32'd0, 1'b0);
      push_request(REQ_INSERT, 32'h02, 32'h3, 32'd2, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd1, 1'b0);
      // An insert in the middle of a code leaves the cursor where it is.
      push_request(REQ_INSERT, 32'h03, 32'h0, 32'd2, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd1, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd0, 1'b0);
      push_request(REQ_DECODE, 32'h00, 32'h0, 32'd0, 32'd1, 1'b0);
      push_request(REQ_CLEAR, 32'h00, 32'h0, 32'd0, 32'd0, 1'b0);

      // Random part: mostly well-formed code sets and their bit streams.
      while (counted_reqs < TARGET_REQS) begin
         episode = $urandom_range(0, 99);
         if (episode < 60) begin
            // Build a prefix-free code by splitting leaves of a growing tree.
            push_request(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0);
            set_bits  = {32'h0};
            set_len   = {0};
            depth_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32)
                                                    : $urandom_range(4, 8);
            leaves    = $urandom_range(2, 16);
            while (set_len.size() < leaves) begin
               pick = $urandom_range(0, set_len.size() - 1);
               if (set_len[pick] < depth_cap) begin
                  set_bits = {set_bits, {set_bits[pick][CODE_W-2:0], 1'b1}};
                  set_len  = {set_len, set_len[pick] + 1};
                  set_bits[pick] = {set_bits[pick][CODE_W-2:0], 1'b0};
                  set_len[pick]++;
               end
            end
            // Bits above the code length carry junk that must be ignored.
            foreach (set_bits[i]) begin
               junk = $urandom;
               push_request(REQ_INSERT, $urandom, set_bits[i] | (junk << set_len[i]),
                            set_len[i], $urandom, 1'b0);
            end
            hold = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(15, 50)) begin
               pick = $urandom_range(0, set_len.size() - 1);
               if ($urandom_range(0, 19) == 0) begin
                  push_request(REQ_DECODE, $urandom, $urandom, $urandom, $urandom, 1'b0);
               end else if ($urandom_range(0, 29) == 0) begin
                  push_request(REQ_INSERT, $urandom, set_bits[pick], set_len[pick],
                               $urandom, 1'b0);
               end else begin
                  for (pos = set_len[pick] - 1; pos >= 0; pos--) begin
                     push_request(REQ_DECODE, $urandom, $urandom, $urandom,
                                  32'(set_bits[pick][pos]), hold);
                     hold = 1'b0;
                  end
               end
            end
         end else if (episode < 75) begin
            // Fill the store with long codes until inserts run out of nodes.
            push_request(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0);
            fill_bits = $urandom;
            fill_len  = $urandom_range(24, 32);
            push_request(REQ_INSERT, $urandom, fill_bits, fill_len, $urandom, 1'b0);
            repeat ($urandom_range(19, 25)) begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63)
                                                 : $urandom_range(24, 32);
               push_request(REQ_INSERT, $urandom, $urandom, len, $urandom, 1'b0);
            end
            for (pos = fill_len - 1; pos >= 0; pos--)
               push_request(REQ_DECODE, $urandom, $urandom, $urandom,
                            32'(fill_bits[pos]), 1'b0);
            repeat ($urandom_range(5, 20))
               push_request(REQ_DECODE, $urandom, $urandom, $urandom, $urandom, 1'b0);
         end else begin
            // Noise on whatever tree is present, including the unused request type.
            repeat ($urandom_range(20, 40)) begin
               t   = $urandom_range(0, 9);
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 6);
               if (t == 0)
                  push_request(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0);
               else if (t <= 3)
                  push_request(REQ_INSERT, $urandom, $urandom, len, $urandom, 1'b0);
               else if (t <= 8)
                  push_request(REQ_DECODE, $urandom, $urandom, $urandom, $urandom, 1'b0);
               else
                  push_request(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b0);
            end
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every outcome to arrive.
      while (accepted_total != queued_total || awaited_outcomes.size() != 0)
         @(negedge clock);
      repeat (100) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("PASS huffman_tree_decoder");
      end else begin
         $display("FAIL huffman_tree_decoder");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4_000_000;
      $display("FAIL huffman_tree_decoder");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/htd_pkg.sv
design/htd_ram.sv
design/htd_core.sv
design/huffman_tree_decoder.sv
tb/huffman_tree_decoder_tb.sv
